// File: rtl/iurf_pkg.sv
// shared types, constants and helpers for the ipv4/udp receive filter
package iurf_pkg;

  localparam int unsigned MaxFrameBytesDefault = 2048;

  localparam logic [7:0]  VerMin         = 8'h45;
  localparam logic [7:0]  VerMax         = 8'h4f;
  localparam logic [7:0]  ProtoUdp       = 8'd17;
  localparam logic [15:0] DhcpClientPort = 16'd68;
  localparam logic [15:0] TftpPortReset  = 16'hc000;
  localparam logic [15:0] UdpSumSeed     = 16'h0011;
  localparam logic [15:0] SumAllOnes     = 16'hffff;
  localparam int unsigned MinIpHeader    = 20;
  localparam int unsigned UdpHeader      = 8;
  localparam logic [10:0] PayloadMax     = 11'h7ff;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HOST_ADDRESS = 8'd0,
    REG_TFTP_PORT    = 8'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    V_TFTP      = 3'd0,
    V_DHCP      = 3'd1,
    V_NO_PORT   = 3'd2,
    V_HDR_REJ   = 3'd3,
    V_BAD_IP_CS = 3'd4,
    V_BAD_UDPCS = 3'd5,
    V_TRUNC     = 3'd6
  } verdict_t;

  // ones-complement 16-bit add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = {1'b0, s[15:0]} + {16'd0, s[16]};
    return t[15:0];
  endfunction

  // byte placed as high or low half of a 16-bit word
  function automatic logic [15:0] byte_word(input logic odd, input logic [7:0] b);
    return odd ? {8'd0, b} : {b, 8'd0};
  endfunction

endpackage

// File: rtl/iurf_in_if.sv
// byte stream channel carrying ip packet bytes
interface iurf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [11:0] frame_length;
  modport source (output valid, data_byte, first_byte, last_byte, frame_length, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, frame_length, output ready);
endinterface

// File: rtl/iurf_out_if.sv
// verdict channel, one transfer per finished frame
interface iurf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [10:0] payload_length;
  logic [31:0] source_address;
  logic [15:0] source_port;
  modport source (output valid, verdict, payload_length, source_address, source_port,
                  input ready);
  modport sink   (input valid, verdict, payload_length, source_address, source_port,
                  output ready);
endinterface

// File: rtl/iurf_cfg_if.sv
// register write channel
interface iurf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [iurf_pkg::CfgIdxW-1:0]   index;
  logic [iurf_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/ipv4_udp_receive_filter_top.sv
// ipv4/udp receive filter: header checks, checksums and port dispatch
//
//  channel | dir | transfers
//  --------+-----+-------------------------------------------------
//  in_ch   | in  | one packet byte, with first/last marks and frame length
//  out_ch  | out | one verdict per frame, after the frame's last byte
//  cfg_ch  | in  | register write: 0 host address, 1 tftp port
//
// one byte is taken every cycle while in_ch.ready is high; after the last byte
// a verdict passes the state update stage, then the decision stage into the output register
// reset clears all frame state; host address 0, tftp port 0xc000
// in_ch.ready drops only while the output register holds an untaken verdict
// cfg_ch.ready is always high
module ipv4_udp_receive_filter_top #(
  parameter int unsigned MAX_FRAME_BYTES = iurf_pkg::MaxFrameBytesDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  iurf_in_if.sink      in_ch,
  iurf_out_if.source   out_ch,
  iurf_cfg_if.sink     cfg_ch
);

  localparam logic [16:0] MaxLen = 17'(MAX_FRAME_BYTES);

  // configuration
  logic [31:0] host_addr_r;
  logic [15:0] tftp_port_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_addr_r <= '0;
      tftp_port_r <= iurf_pkg::TftpPortReset;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        iurf_pkg::REG_HOST_ADDRESS: host_addr_r <= cfg_ch.data;
        iurf_pkg::REG_TFTP_PORT:    tftp_port_r <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline advance: the decision stage may move when the output is free
  logic adv;
  logic out_v_r;
  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  logic take;
  assign take = in_ch.valid && adv;

  // per-frame parse state
  logic        open_r,  open_nxt;
  logic [11:0] bc_r,    bc_nxt;
  logic [5:0]  hb_r,    hb_nxt;
  logic [15:0] tl_r,    tl_nxt;
  logic [15:0] ipsum_r, ipsum_nxt;
  logic [15:0] usum_r,  usum_nxt;
  logic [15:0] psum_r,  psum_nxt;    // pseudo-header: addresses and udp length
  logic [7:0]  held_r,  held_nxt;
  logic [31:0] saddr_r, saddr_nxt;
  logic [31:0] daddr_r, daddr_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [15:0] ulen_r,  ulen_nxt;
  logic [15:0] ucsf_r,  ucsf_nxt;
  logic [2:0]  rej_r,   rej_nxt;
  logic [11:0] flen_r,  flen_nxt;
  logic        fin;

  always_comb begin
    logic [11:0] p;
    logic [11:0] u;
    logic [7:0]  b;
    logic [16:0] tl_new;
    logic [31:0] dst_new;
    b = in_ch.data_byte;
    // frame start loads the cleared values
    if (in_ch.first_byte) begin
      open_nxt = 1'b1;  bc_nxt = '0;  hb_nxt = '0;  tl_nxt = '0;
      ipsum_nxt = '0;  usum_nxt = iurf_pkg::UdpSumSeed;  psum_nxt = '0;
      held_nxt = '0;  saddr_nxt = '0;  daddr_nxt = '0;
      sport_nxt = '0;  dport_nxt = '0;  ulen_nxt = '0;  ucsf_nxt = '0;
      rej_nxt = '0;  flen_nxt = in_ch.frame_length;
    end else begin
      open_nxt = open_r;  bc_nxt = bc_r;  hb_nxt = hb_r;  tl_nxt = tl_r;
      ipsum_nxt = ipsum_r;  usum_nxt = usum_r;  psum_nxt = psum_r;
      held_nxt = held_r;  saddr_nxt = saddr_r;  daddr_nxt = daddr_r;
      sport_nxt = sport_r;  dport_nxt = dport_r;  ulen_nxt = ulen_r;
      ucsf_nxt = ucsf_r;  rej_nxt = rej_r;  flen_nxt = flen_r;
    end
    p       = bc_nxt;
    u       = p - 12'(hb_nxt);
    tl_new  = {1'b0, tl_nxt[15:8], b};
    dst_new = {daddr_nxt[23:0], b};
    fin     = open_nxt && in_ch.last_byte;

    if (open_nxt) begin
      if (p != 12'hfff) bc_nxt = p + 12'd1;
      if (rej_nxt == '0) begin
        if (p < 12'(iurf_pkg::MinIpHeader) || p < 12'(hb_nxt)) begin
          case (p)
            12'd0: begin
              hb_nxt = {b[3:0], 2'b00};
              if (b < iurf_pkg::VerMin || b > iurf_pkg::VerMax) rej_nxt = iurf_pkg::V_HDR_REJ;
            end
            12'd2: tl_nxt = {b, 8'd0};
            12'd3: begin
              tl_nxt = tl_new[15:0];
              if (tl_new > {5'd0, flen_nxt} || tl_new > MaxLen) rej_nxt = iurf_pkg::V_HDR_REJ;
            end
            12'd6: held_nxt = b;
            12'd7: if ({held_nxt[4:0], b} != 13'd0) rej_nxt = iurf_pkg::V_HDR_REJ;
            12'd9: if (b != iurf_pkg::ProtoUdp) rej_nxt = iurf_pkg::V_HDR_REJ;
            12'd12, 12'd13, 12'd14, 12'd15: saddr_nxt = {saddr_nxt[23:0], b};
            12'd16, 12'd17, 12'd18: daddr_nxt = dst_new;
            12'd19: begin
              daddr_nxt = dst_new;
              if (host_addr_r != '0 && dst_new != host_addr_r) rej_nxt = iurf_pkg::V_HDR_REJ;
            end
            default: ;
          endcase
          // addresses also feed the pseudo-header sum
          if (p >= 12'd12 && p <= 12'd19)
            psum_nxt = iurf_pkg::oc_add(psum_nxt, iurf_pkg::byte_word(p[0], b));
          ipsum_nxt = iurf_pkg::oc_add(ipsum_nxt, iurf_pkg::byte_word(p[0], b));
          if (rej_nxt == '0 && (p + 12'd1) == 12'(hb_nxt) && ipsum_nxt != iurf_pkg::SumAllOnes)
            rej_nxt = iurf_pkg::V_BAD_IP_CS;
        end else if ({4'd0, p} < tl_nxt) begin
          case (u)
            12'd0, 12'd1: sport_nxt = {sport_nxt[7:0], b};
            12'd2, 12'd3: dport_nxt = {dport_nxt[7:0], b};
            12'd4, 12'd5: begin
              ulen_nxt = {ulen_nxt[7:0], b};
              psum_nxt = iurf_pkg::oc_add(psum_nxt, iurf_pkg::byte_word(u[0], b));
            end
            12'd6, 12'd7: ucsf_nxt = {ucsf_nxt[7:0], b};
            default: ;
          endcase
          if (u < 12'(iurf_pkg::UdpHeader) || {4'd0, u} < ulen_nxt)
            usum_nxt = iurf_pkg::oc_add(usum_nxt, iurf_pkg::byte_word(u[0], b));
        end
      end
      if (in_ch.last_byte) open_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;  bc_r <= '0;  hb_r <= '0;  tl_r <= '0;
      ipsum_r <= '0;  usum_r <= iurf_pkg::UdpSumSeed;  psum_r <= '0;
      held_r <= '0;  saddr_r <= '0;  daddr_r <= '0;  sport_r <= '0;
      dport_r <= '0;  ulen_r <= '0;  ucsf_r <= '0;  rej_r <= '0;  flen_r <= '0;
    end else if (take) begin
      open_r <= open_nxt;  bc_r <= bc_nxt;  hb_r <= hb_nxt;  tl_r <= tl_nxt;
      ipsum_r <= ipsum_nxt;  usum_r <= usum_nxt;  psum_r <= psum_nxt;
      held_r <= held_nxt;  saddr_r <= saddr_nxt;  daddr_r <= daddr_nxt;
      sport_r <= sport_nxt;  dport_r <= dport_nxt;  ulen_r <= ulen_nxt;
      ucsf_r <= ucsf_nxt;  rej_r <= rej_nxt;  flen_r <= flen_nxt;
    end
  end

  // snapshot of a finished frame, so the next frame can start at once
  logic        d_v_r;
  logic [2:0]  d_rej_r;
  logic [11:0] d_bc_r;
  logic [5:0]  d_hb_r;
  logic [15:0] d_tl_r, d_ulen_r, d_ucsf_r, d_usum_r, d_psum_r, d_dport_r, d_sport_r;
  logic [31:0] d_saddr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r <= take && fin;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fin) begin
      d_rej_r <= rej_nxt;  d_bc_r <= bc_nxt;  d_hb_r <= hb_nxt;  d_tl_r <= tl_nxt;
      d_ulen_r <= ulen_nxt;  d_ucsf_r <= ucsf_nxt;  d_usum_r <= usum_nxt;
      d_psum_r <= psum_nxt;  d_dport_r <= dport_nxt;  d_sport_r <= sport_nxt;
      d_saddr_r <= saddr_nxt;
    end
  end

  // decision
  logic [2:0]  verd;
  logic [10:0] plen;

  always_comb begin
    logic [15:0] seg;
    logic [11:0] got;
    logic [15:0] cs;
    logic [15:0] pl;
    seg = d_tl_r - 16'(d_hb_r);
    got = d_bc_r - 12'(d_hb_r);
    cs  = iurf_pkg::oc_add(d_usum_r, d_psum_r);
    if (d_rej_r != '0)
      verd = d_rej_r;
    else if (d_bc_r < 12'(iurf_pkg::MinIpHeader) || d_bc_r < 12'(d_hb_r))
      verd = iurf_pkg::V_TRUNC;
    else if (d_tl_r < 16'(d_hb_r))
      verd = iurf_pkg::V_TRUNC;
    else if (seg < 16'(iurf_pkg::UdpHeader) || seg < d_ulen_r)
      verd = iurf_pkg::V_TRUNC;
    else if ({4'd0, got} < seg)
      verd = iurf_pkg::V_TRUNC;
    else if (d_ucsf_r != '0 && cs != iurf_pkg::SumAllOnes)
      verd = iurf_pkg::V_BAD_UDPCS;
    else if (d_dport_r == tftp_port_r)
      verd = iurf_pkg::V_TFTP;
    else if (d_dport_r == iurf_pkg::DhcpClientPort)
      verd = iurf_pkg::V_DHCP;
    else
      verd = iurf_pkg::V_NO_PORT;
    pl = d_ulen_r - 16'(iurf_pkg::UdpHeader);
    if (verd != iurf_pkg::V_TFTP && verd != iurf_pkg::V_DHCP)
      plen = '0;
    else if (d_ulen_r < 16'(iurf_pkg::UdpHeader))
      plen = '0;
    else if (pl > 16'(iurf_pkg::PayloadMax))
      plen = iurf_pkg::PayloadMax;
    else
      plen = pl[10:0];
  end

  // output register
  logic [2:0]  out_verd_r;
  logic [10:0] out_plen_r;
  logic [31:0] out_saddr_r;
  logic [15:0] out_sport_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d_v_r) begin
      out_verd_r  <= verd;
      out_plen_r  <= plen;
      out_saddr_r <= d_saddr_r;
      out_sport_r <= d_sport_r;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.verdict        = out_verd_r;
  assign out_ch.payload_length = out_plen_r;
  assign out_ch.source_address = out_saddr_r;
  assign out_ch.source_port    = out_sport_r;

endmodule

// File: rtl/iurf_checker.sv
// port-level assertions for the ipv4/udp receive filter, bound to the top level
module iurf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  verdict,
  input logic [10:0] payload_length
);

  // input stalls only behind an untaken verdict
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready not tied to output backpressure");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(verdict))
    else $error("stalled verdict changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> verdict <= iurf_pkg::V_TRUNC)
    else $error("verdict code out of range");

  a_plen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && verdict != iurf_pkg::V_TFTP && verdict != iurf_pkg::V_DHCP
      |-> payload_length == '0)
    else $error("payload length on a dropped packet");

endmodule

bind ipv4_udp_receive_filter_top iurf_checker u_iurf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .verdict        (out_ch.verdict),
  .payload_length (out_ch.payload_length)
);
